### design/bhpq_pkg.sv
// shared types, constants and the key compare for the heap priority queue
`default_nettype none

package bhpq_pkg;

    localparam int DEPTH    = 256;
    localparam int KEY_BITS = 32;
    localparam int TAG_BITS = 16;

    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int IDX_W   = ADDR_W + 2;
    localparam int ENTRY_W = KEY_BITS + TAG_BITS;

    // operation codes
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                mode;
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
    } t_item;

    typedef struct packed {
        logic [1:0]          status;
        logic [KEY_BITS-1:0] out_key;
        logic [TAG_BITS-1:0] out_tag;
        logic [CNT_W-1:0]    fill;
    } t_result;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
    } t_entry;

    // commands from the controller, one per controller step
    typedef struct packed {
        logic capture;
        logic check;
        logic pop_ld;
        logic walk_cmp;
        logic walk_last;
        logic up_rd;
        logic up_cmp;
    } t_cmd;

    // status from the datapath
    typedef struct packed {
        logic refused;
        logic is_pop;
        logic walk_more;
        logic walk_last;
        logic last_zero;
        logic pos_zero;
        logic up_swap;
        logic par_zero;
    } t_stat;

    // a precedes b under the current order
    function automatic logic precedes(input logic [KEY_BITS-1:0] a,
                                      input logic [KEY_BITS-1:0] b,
                                      input logic                min_first);
        return min_first ? (a < b) : (a > b);
    endfunction

endpackage

`default_nettype wire

### design/bhpq_ram.sv
// generic ram: one write port, two registered read ports
`default_nettype none

module bhpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic      [WIDTH-1:0]         o_rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

### design/bhpq_ctrl.sv
// controller state machine for the heap priority queue
`default_nettype none

module bhpq_ctrl
    import bhpq_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output logic       o_busy,
    output logic       o_done
);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_CHECK     = 9'b000000010,
        S_POP_LD    = 9'b000000100,
        S_WALK_CMP  = 9'b000001000,
        S_WALK_LAST = 9'b000010000,
        S_UP_RD     = 9'b000100000,
        S_UP_CMP    = 9'b001000000,
        S_FIN       = 9'b010000000,
        S_SPARE     = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.refused)     n_state = S_FIN;
                else if (i_stat.is_pop) n_state = S_POP_LD;
                else                    n_state = S_UP_RD;
            end
            S_POP_LD, S_WALK_CMP: begin
                if (i_stat.walk_more)      n_state = S_WALK_CMP;
                else if (i_stat.walk_last) n_state = S_WALK_LAST;
                else if (i_stat.last_zero) n_state = S_FIN;
                else                       n_state = S_UP_RD;
            end
            S_WALK_LAST: begin
                n_state = S_UP_RD;
            end
            S_UP_RD: begin
                if (i_stat.pos_zero) n_state = S_FIN;
                else                 n_state = S_UP_CMP;
            end
            S_UP_CMP: begin
                if (!i_stat.up_swap)      n_state = S_FIN;
                else if (i_stat.par_zero) n_state = S_UP_RD;
                else                      n_state = S_UP_CMP;
            end
            S_FIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // step commands
    always_comb begin
        o_cmd.capture   = (r_state == S_IDLE) && i_start;
        o_cmd.check     = (r_state == S_CHECK);
        o_cmd.pop_ld    = (r_state == S_POP_LD);
        o_cmd.walk_cmp  = (r_state == S_WALK_CMP);
        o_cmd.walk_last = (r_state == S_WALK_LAST);
        o_cmd.up_rd     = (r_state == S_UP_RD);
        o_cmd.up_cmp    = (r_state == S_UP_CMP);
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_FIN);

endmodule

`default_nettype wire

### design/bhpq_dp.sv
// datapath: heap memory, index registers, compare and result registers
`default_nettype none

module bhpq_dp
    import bhpq_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cmd  i_cmd,
    input  wire t_item i_item,
    input  wire logic  i_cfg_we,
    input  wire logic  i_cfg_data,
    output t_stat      o_stat,
    output t_result    o_result
);

    t_item               r_item;
    logic                r_min_first;
    logic [CNT_W-1:0]    r_count;
    logic [ADDR_W-1:0]   r_last;
    logic [ADDR_W-1:0]   r_hole;
    logic [ADDR_W-1:0]   r_pos;
    t_entry              r_lk;
    logic [1:0]          r_status;
    logic [KEY_BITS-1:0] r_rkey;
    logic [TAG_BITS-1:0] r_rtag;

    t_entry            rd_a, rd_b, wdata;
    logic              we;
    logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
    logic [ADDR_W-1:0] par, gpar, h_nx;
    logic [IDX_W-1:0]  right_cur, right_nx, right_nx_m1, last_ext;
    logic [CNT_W-1:0]  count_m1;
    logic              pick_left, up_swap, is_pop, refused;

    // heap storage
    bhpq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .o_rdata_a (rd_a),
        .i_raddr_b (raddr_b),
        .o_rdata_b (rd_b)
    );

    // index arithmetic and compares
    assign is_pop      = (r_item.mode == MODE_POP);
    assign count_m1    = r_count - CNT_W'(1);
    assign refused     = is_pop ? (r_count == '0) : (r_count == CNT_W'(DEPTH));
    assign par         = (r_pos - ADDR_W'(1)) >> 1;
    assign gpar        = (par - ADDR_W'(1)) >> 1;
    assign right_cur   = IDX_W'({r_hole, 1'b0}) + IDX_W'(2);
    assign pick_left   = precedes(rd_a.key, rd_b.key, r_min_first);
    assign up_swap     = precedes(r_lk.key, rd_a.key, r_min_first);
    assign h_nx        = i_cmd.walk_cmp
                         ? (pick_left ? ADDR_W'(right_cur - IDX_W'(1)) : ADDR_W'(right_cur))
                         : r_hole;
    assign right_nx    = IDX_W'({h_nx, 1'b0}) + IDX_W'(2);
    assign right_nx_m1 = right_nx - IDX_W'(1);
    assign last_ext    = IDX_W'(r_last);

    // status to the controller
    always_comb begin
        o_stat.refused   = refused;
        o_stat.is_pop    = is_pop;
        o_stat.walk_more = (right_nx < last_ext);
        o_stat.walk_last = (right_nx == last_ext);
        o_stat.last_zero = (r_last == '0);
        o_stat.pos_zero  = (r_pos == '0);
        o_stat.up_swap   = up_swap;
        o_stat.par_zero  = (par == '0);
    end

    // read addresses
    always_comb begin
        raddr_a = par;
        raddr_b = '0;
        priority if (i_cmd.check) begin
            raddr_a = '0;
            raddr_b = count_m1[ADDR_W-1:0];
        end else if (i_cmd.pop_ld || i_cmd.walk_cmp) begin
            raddr_a = right_nx_m1[ADDR_W-1:0];
            raddr_b = right_nx[ADDR_W-1:0];
        end else if (i_cmd.up_cmp) begin
            raddr_a = gpar;
        end
    end

    // write port
    always_comb begin
        we    = 1'b0;
        waddr = r_hole;
        wdata = r_lk;
        priority if (i_cmd.walk_cmp) begin
            we    = 1'b1;
            wdata = pick_left ? rd_a : rd_b;
        end else if (i_cmd.walk_last) begin
            we    = 1'b1;
            wdata = rd_a;
        end else if (i_cmd.up_rd) begin
            we    = (r_pos == '0);
            waddr = r_pos;
        end else if (i_cmd.up_cmp) begin
            we    = 1'b1;
            waddr = r_pos;
            wdata = up_swap ? rd_a : r_lk;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_min_first <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_min_first <= i_cfg_data;
            end
            if (i_cmd.check && !refused) begin
                r_count <= is_pop ? count_m1 : (r_count + CNT_W'(1));
            end
        end
    end

    // payload and index registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
        if (i_cmd.check) begin
            r_rkey   <= '0;
            r_rtag   <= '0;
            r_status <= refused ? (is_pop ? ST_EMPTY : ST_FULL) : ST_OK;
            r_last   <= count_m1[ADDR_W-1:0];
            r_hole   <= '0;
            r_pos    <= r_count[ADDR_W-1:0];
            r_lk     <= '{key: r_item.key, tag: r_item.tag};
        end
        if (i_cmd.pop_ld) begin
            r_rkey <= rd_a.key;
            r_rtag <= rd_a.tag;
            r_lk   <= rd_b;
        end
        if (i_cmd.pop_ld || i_cmd.walk_cmp) begin
            r_hole <= h_nx;
            r_pos  <= h_nx;
        end
        // hole ends on the left child, the one just before the last entry
        if (i_cmd.walk_last) begin
            r_pos <= r_last - ADDR_W'(1);
        end
        if (i_cmd.up_cmp && up_swap) begin
            r_pos <= par;
        end
    end

    // result
    always_comb begin
        o_result.status  = r_status;
        o_result.out_key = r_rkey;
        o_result.out_tag = r_rtag;
        o_result.fill    = r_count;
    end

endmodule

`default_nettype wire

### design/binary_heap_priority_queue.sv
// top level of the binary heap priority queue
//
// Command channel: an operation (push key and tag, or pop the front entry) is
// taken at a rising edge with start high and busy low. Its result is shown on
// o_result for exactly one cycle with o_done high; there is no back pressure.
// Status tells ok, push refused (full) or pop refused (empty); fill is the
// entry count after the operation; out_key and out_tag carry the popped entry
// and read zero otherwise.
// Configuration: one bit, min_first, written through i_cfg_valid/o_cfg_ready
// while no operation is in flight (0 pops the largest key, 1 the smallest).
// The heap memory has one write and two read ports, so each tree level is
// handled in one controller step. busy falls in the cycle after o_done, so
// the next operation is accepted in the cycle after the result at the
// earliest.
// Reset (synchronous, active low) empties the queue and selects max-first;
// the heap memory is not cleared and needs no clearing pass.
`default_nettype none

module binary_heap_priority_queue
    import bhpq_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  start,
    output logic       busy,
    input  wire t_item i_item,
    output logic       o_done,
    output t_result    o_result,
    input  wire logic  i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire logic  i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    // sequencing
    bhpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    // storage and arithmetic
    bhpq_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_stat     (stat),
        .o_result   (o_result)
    );

    // config transactions are taken while idle
    assign o_cfg_ready = !busy;

endmodule

`default_nettype wire

### design/bhpq_chk.sv
// port-level checker for the heap priority queue, bound to the top level
`default_nettype none

module bhpq_chk
    import bhpq_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire logic    o_done,
    input wire t_result o_result
);

    // an accepted transaction keeps the block busy
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted transaction");

    // the block is free again right after a result
    a_idle_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("busy still high after result");

    // refused operations return no entry
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.status != ST_OK |->
            o_result.out_key == '0 && o_result.out_tag == '0)
        else $error("refused operation returned an entry");

    // empty refusal only with no entries
    a_empty_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.status == ST_EMPTY |-> o_result.fill == '0)
        else $error("empty refusal with entries held");

    // full refusal only at capacity
    a_full_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.status == ST_FULL |-> o_result.fill == CNT_W'(DEPTH))
        else $error("full refusal below capacity");

endmodule

bind binary_heap_priority_queue bhpq_chk u_bhpq_chk (.*);

`default_nettype wire
